### hw/rtl/lsm_pkg.sv
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and codes for the bounded LIFO stack with running maximum.
// ----------------------------------------------------------------------------
package lsm_pkg;

    // field widths of the request and response items
    localparam int ITEM_W   = 32;
    localparam int MAXV_W   = 31;
    localparam int CNT_W    = 9;
    localparam int LIMIT_W  = 9;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // default number of cells
    localparam int DEPTH_DEF = 256;

    // reset value of the limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

    // operation codes (any other code behaves as a query)
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // request item
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [ITEM_W-1:0] value;
    } t_req;

    // response item
    typedef struct packed {
        logic signed [ITEM_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [CNT_W-1:0]         count;
        logic [MAXV_W-1:0]        max_value;
    } t_rsp;

    // contents of one stack cell: item and prefix maximum down to it
    typedef struct packed {
        logic signed [ITEM_W-1:0] item;
        logic [MAXV_W-1:0]        maxv;
    } t_entry;

    // shift control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

### hw/rtl/lsm_cell.sv
// ----------------------------------------------------------------------------
// lsm_cell
// One stack cell: takes the entry above on a push, the entry below on a pop.
// ----------------------------------------------------------------------------
module lsm_cell
    import lsm_pkg::*;
(
    input  logic       i_clk,
    input  t_shift_ctl i_ctl,
    input  t_entry     i_upper,
    input  t_entry     i_lower,
    output t_entry     o_q
);

    t_entry r_q;
    t_entry n_q;

    // shift selection
    always_comb begin
        n_q = r_q;
        if (i_ctl.push) begin
            n_q = i_upper;
        end else if (i_ctl.pop) begin
            n_q = i_lower;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

### hw/rtl/lifo_stack_with_max.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_max
// Bounded LIFO stack of signed items built as a row of shifting cells; every
// cell keeps its item and the prefix maximum, so the top cell gives the max.
//
//  channel   ports                          transfer
//  request   start, busy, i_req             start high while busy low
//  response  o_valid, o_rsp                 o_valid high for one cycle
//  config    i_cfg_valid, o_cfg_ready,      i_cfg_valid and o_cfg_ready high
//            i_cfg_data
//
// One item per cycle: busy never rises, and the response of an item shows
// in the cycle after its transfer. Push and pop move every cell by one place
// in the cycle of the transfer, so the cell row sets the rate.
// Reset clears the count, the limit (to 256) and the response strobe; the
// cells are not cleared and are read only after a push wrote them.
// The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module lifo_stack_with_max
    import lsm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    output logic               o_valid,
    output t_rsp               o_rsp,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;

    logic               w_accept;
    logic               w_empty;
    logic               w_full;
    logic [CMPW-1:0]    w_lim;
    logic [MAXV_W-1:0]  w_cur_max;
    logic [MAXV_W-1:0]  w_new_max;
    t_entry             w_new;
    t_shift_ctl         w_ctl;
    t_entry             w_q [DEPTH+1];

    // handshakes
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // effective limit clamped to 1..DEPTH
    always_comb begin
        w_lim = CMPW'(r_limit);
        if (w_lim == '0) begin
            w_lim = CMPW'(1);
        end
        if (w_lim > CMPW'(DEPTH)) begin
            w_lim = CMPW'(DEPTH);
        end
    end

    assign w_empty   = (r_count == '0);
    assign w_full    = (CMPW'(r_count) >= w_lim);
    assign w_cur_max = w_empty ? '0 : w_q[0].maxv;

    // prefix maximum for a pushed item; negatives never win over zero
    always_comb begin
        w_new_max = w_cur_max;
        if (!i_req.value[ITEM_W-1] && (i_req.value[MAXV_W-1:0] > w_cur_max)) begin
            w_new_max = i_req.value[MAXV_W-1:0];
        end
        w_new.item = i_req.value;
        w_new.maxv = w_new_max;
    end

    // operation decode and response build
    always_comb begin
        w_ctl           = '0;
        n_count         = r_count;
        n_rsp.data      = '0;
        n_rsp.status    = ST_OK;
        n_rsp.count     = CNT_W'(r_count);
        n_rsp.max_value = w_cur_max;
        case (i_req.op)
            OP_PUSH: begin
                if (w_full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    w_ctl.push      = w_accept;
                    n_count         = r_count + 1'b1;
                    n_rsp.data      = i_req.value;
                    n_rsp.max_value = w_new_max;
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    w_ctl.pop       = w_accept;
                    n_count         = r_count - 1'b1;
                    n_rsp.data      = w_q[0].item;
                    n_rsp.max_value = (r_count == CW'(1)) ? '0 : w_q[1].maxv;
                end
            end
            default: begin
                if (w_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.data = w_q[0].item;
                end
            end
        endcase
        n_rsp.count = CNT_W'(n_count);
    end

    // count and response registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // row of cells, top of stack in cell 0
    assign w_q[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_upper;
        if (i == 0) begin : g_top
            assign w_upper = w_new;
        end else begin : g_mid
            assign w_upper = w_q[i-1];
        end
        lsm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_upper (w_upper),
            .i_lower (w_q[i+1]),
            .o_q     (w_q[i])
        );
    end

endmodule
